>>> rtl/rsaenc_pkg.sv
// Package for the small-modulus RSA character encryptor.
// Holds constants, register indexes, payload structs and control types.
// No dependencies.
package rsaenc_pkg;

  localparam int PRIME_WIDTH_DEF = 8;
  localparam int PT_OFFSET       = 96;
  localparam int RESET_P         = 23;
  localparam int RESET_Q         = 41;
  localparam int CFG_ADDR_W      = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_PRIME_P = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_PRIME_Q = CFG_ADDR_W'(1);

  typedef struct packed {
    logic signed [7:0] message_char;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0] cipher_residue;
    logic [7:0]         cipher_byte;
    logic [15:0]        public_exponent;
    logic [15:0]        private_exponent;
    logic               last_out;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_KEY_INIT,
    OP_NEXT_I,
    OP_PRIME_INIT,
    OP_NEXT_F,
    OP_SET_E,
    OP_ACC_ADD,
    OP_SET_D,
    OP_EXP_INIT,
    OP_MUL,
    OP_SET_R,
    OP_DIV_T,
    OP_DIV_PRIME,
    OP_DIV_D,
    OP_DIV_EXP,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic prime_small;   // p or q below two
    logic i_ge_t;        // candidate search exhausted
    logic i_is_pq;       // candidate equals a configured prime
    logic fsq_gt_i;      // trial factor squared passed candidate
    logic div_done;
    logic div_rem_zero;
    logic cnt_zero;      // exponent steps finished
  } dp_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KEY_INIT,
    S_KEY_CHK,
    S_CAND,
    S_DIV_T,
    S_PRIME,
    S_DIV_F,
    S_ACC,
    S_DIV_D_ST,
    S_DIV_D,
    S_EXP_INIT,
    S_EXP_MUL,
    S_EXP_DIV_ST,
    S_EXP_DIV,
    S_OUT
  } ctrl_state_t;

endpackage

>>> rtl/toy_rsa_char_encryptor.sv
// Small-modulus RSA character encryptor, top level. Uses rsaenc_pkg,
// rsaenc_ctrl and rsaenc_dp (with rsaenc_div inside).
// Modular-power steps use the one-bit-per-cycle remainder unit, whose dividend
// is DW = 2*PRIME_WIDTH+8 bits wide; e=3 at reset primes. Sync active-low reset.
// First item after reset or a prime write also pays for key derivation.
// One item at a time; input stalls until the result is registered.
module toy_rsa_char_encryptor
  import rsaenc_pkg::*;
#(
  parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [PRIME_WIDTH-1:0] cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_hit;

  assign cfg_hit = cfg_we && ((cfg_addr == REG_PRIME_P) || (cfg_addr == REG_PRIME_Q));

  rsaenc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_hit   (cfg_hit),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsaenc_dp #(
    .PRIME_WIDTH(PRIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

>>> rtl/rsaenc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Unsigned dividend and divisor; gives quotient and remainder.
// Depends on nothing but its parameters.
module rsaenc_div #(
  parameter int NW = 16,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [NW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] dvs_r, dvs_nxt;
  logic [NW:0]   sh;
  logic [NW:0]   diff;
  logic          ge;

  always_comb begin
    sh   = {rem_r, quo_r[DW-1]};
    diff = sh - {1'b0, dvs_r};
    ge   = (sh >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[NW-1:0] : sh[NW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

>>> rtl/rsaenc_dp.sv
// Datapath: prime registers, key registers, exponent search, modular power.
// Driven by rsaenc_ctrl through dp_cmd_t; uses rsaenc_pkg and rsaenc_div.
module rsaenc_dp
  import rsaenc_pkg::*;
#(
  parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [PRIME_WIDTH-1:0] cfg_wdata,
  input  in_item_t               in_data,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  output out_item_t              out_data
);

  localparam int PW = PRIME_WIDTH;
  localparam int NW = 2 * PW;
  localparam int DW = NW + 8;

  logic [PW-1:0]   p_r, p_nxt;
  logic [PW-1:0]   q_r, q_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic [NW-1:0]   t_r, t_nxt;
  logic [NW-1:0]   i_r, i_nxt;
  logic [NW-1:0]   f_r, f_nxt;
  logic [NW:0]     fsq_r, fsq_nxt;
  logic [NW-1:0]   e_r, e_nxt;
  logic [NW-1:0]   d_r, d_nxt;
  logic [DW-1:0]   acc_r, acc_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic [NW-1:0]   r_mag_r, r_mag_nxt;
  logic            r_neg_r, r_neg_nxt;
  logic [7:0]      pt_mag_r, pt_mag_nxt;
  logic            pt_neg_r, pt_neg_nxt;
  logic [DW-1:0]   prod_r, prod_nxt;
  logic            prod_neg_r, prod_neg_nxt;
  logic            last_r, last_nxt;
  out_item_t       out_r, out_nxt;

  logic            div_start;
  logic [DW-1:0]   div_dividend;
  logic [NW-1:0]   div_divisor;
  logic            div_done;
  logic [DW-1:0]   div_quot;
  logic [NW-1:0]   div_rem;

  logic signed [8:0]  pt_s;
  logic signed [8:0]  pt_abs;
  logic signed [NW:0] res_s;

  rsaenc_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    pt_s   = 9'(in_data.message_char) - 9'(PT_OFFSET);
    pt_abs = -pt_s;
    res_s  = r_neg_r ? -$signed({1'b0, r_mag_r}) : $signed({1'b0, r_mag_r});
  end

  // configuration registers
  always_comb begin
    p_nxt = p_r;
    q_nxt = q_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_PRIME_P: p_nxt = cfg_wdata;
        REG_PRIME_Q: q_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (cmd.op)
      OP_DIV_T: begin
        div_start    = 1'b1;
        div_dividend = DW'(t_r);
        div_divisor  = i_r;
      end
      OP_DIV_PRIME: begin
        div_start    = 1'b1;
        div_dividend = DW'(i_r);
        div_divisor  = f_r;
      end
      OP_DIV_D: begin
        div_start    = 1'b1;
        div_dividend = acc_r;
        div_divisor  = e_r;
      end
      OP_DIV_EXP: begin
        div_start    = 1'b1;
        div_dividend = prod_r;
        div_divisor  = n_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    n_nxt        = n_r;
    t_nxt        = t_r;
    i_nxt        = i_r;
    f_nxt        = f_r;
    fsq_nxt      = fsq_r;
    e_nxt        = e_r;
    d_nxt        = d_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    r_mag_nxt    = r_mag_r;
    r_neg_nxt    = r_neg_r;
    pt_mag_nxt   = pt_mag_r;
    pt_neg_nxt   = pt_neg_r;
    prod_nxt     = prod_r;
    prod_neg_nxt = prod_neg_r;
    last_nxt     = last_r;
    out_nxt      = out_r;
    unique case (cmd.op)
      OP_LOAD: begin
        pt_neg_nxt = pt_s[8];
        pt_mag_nxt = pt_s[8] ? pt_abs[7:0] : pt_s[7:0];
        last_nxt   = in_data.last_char;
      end
      OP_KEY_INIT: begin
        n_nxt = NW'(p_r) * NW'(q_r);
        t_nxt = NW'(p_r - PW'(1)) * NW'(q_r - PW'(1));
        e_nxt = '0;
        d_nxt = '0;
        i_nxt = NW'(2);
      end
      OP_NEXT_I:     i_nxt = i_r + NW'(1);
      OP_PRIME_INIT: begin
        f_nxt   = NW'(2);
        fsq_nxt = (NW + 1)'(4);
      end
      OP_NEXT_F: begin
        fsq_nxt = fsq_r + {f_r, 1'b1};
        f_nxt   = f_r + NW'(1);
      end
      OP_SET_E: begin
        e_nxt   = i_r;
        acc_nxt = DW'(1);
      end
      OP_ACC_ADD: acc_nxt = acc_r + DW'(t_r);
      OP_SET_D:   d_nxt = div_quot[NW-1:0];
      OP_EXP_INIT: begin
        r_mag_nxt = (e_r == '0) ? '0 : NW'(1);
        r_neg_nxt = 1'b0;
        cnt_nxt   = e_r;
      end
      OP_MUL: begin
        prod_nxt     = DW'(r_mag_r) * DW'(pt_mag_r);
        prod_neg_nxt = r_neg_r ^ pt_neg_r;
        cnt_nxt      = cnt_r - NW'(1);
      end
      OP_SET_R: begin
        r_mag_nxt = div_rem;
        r_neg_nxt = prod_neg_r && (div_rem != '0);
      end
      OP_OUT: begin
        out_nxt.cipher_residue   = 17'(res_s);
        out_nxt.cipher_byte      = res_s[7:0] + 8'(PT_OFFSET);
        out_nxt.public_exponent  = 16'(e_r);
        out_nxt.private_exponent = 16'(d_r);
        out_nxt.last_out         = last_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= PW'(RESET_P);
      q_r <= PW'(RESET_Q);
    end else begin
      p_r <= p_nxt;
      q_r <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    t_r        <= t_nxt;
    i_r        <= i_nxt;
    f_r        <= f_nxt;
    fsq_r      <= fsq_nxt;
    e_r        <= e_nxt;
    d_r        <= d_nxt;
    acc_r      <= acc_nxt;
    cnt_r      <= cnt_nxt;
    r_mag_r    <= r_mag_nxt;
    r_neg_r    <= r_neg_nxt;
    pt_mag_r   <= pt_mag_nxt;
    pt_neg_r   <= pt_neg_nxt;
    prod_r     <= prod_nxt;
    prod_neg_r <= prod_neg_nxt;
    last_r     <= last_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    sts.prime_small  = (p_r < PW'(2)) || (q_r < PW'(2));
    sts.i_ge_t       = (i_r >= t_r);
    sts.i_is_pq      = (i_r == NW'(p_r)) || (i_r == NW'(q_r));
    sts.fsq_gt_i     = (fsq_r > {1'b0, i_r});
    sts.div_done     = div_done;
    sts.div_rem_zero = (div_rem == '0);
    sts.cnt_zero     = (cnt_r == '0);
  end

  assign out_data = out_r;

endmodule

>>> rtl/rsaenc_ctrl.sv
// Controller: sequences key derivation and the modular power per character,
// owns the key-valid flag and the output valid. Uses rsaenc_pkg.
module rsaenc_ctrl
  import rsaenc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cfg_hit,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        keys_valid_r, keys_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = keys_valid_r ? S_EXP_INIT : S_KEY_INIT;
      end
      S_KEY_INIT: state_nxt = S_KEY_CHK;
      S_KEY_CHK:  state_nxt = sts.prime_small ? S_EXP_INIT : S_CAND;
      S_CAND: begin
        if (sts.i_ge_t) state_nxt = S_EXP_INIT;
        else if (!sts.i_is_pq) state_nxt = S_DIV_T;
      end
      S_DIV_T: begin
        if (sts.div_done) state_nxt = sts.div_rem_zero ? S_CAND : S_PRIME;
      end
      S_PRIME:    state_nxt = sts.fsq_gt_i ? S_ACC : S_DIV_F;
      S_DIV_F: begin
        if (sts.div_done) state_nxt = sts.div_rem_zero ? S_CAND : S_PRIME;
      end
      S_ACC:      state_nxt = S_DIV_D_ST;
      S_DIV_D_ST: state_nxt = S_DIV_D;
      S_DIV_D: begin
        if (sts.div_done) state_nxt = sts.div_rem_zero ? S_EXP_INIT : S_ACC;
      end
      S_EXP_INIT: state_nxt = S_EXP_MUL;
      S_EXP_MUL:  state_nxt = sts.cnt_zero ? S_OUT : S_EXP_DIV_ST;
      S_EXP_DIV_ST: state_nxt = S_EXP_DIV;
      S_EXP_DIV: begin
        if (sts.div_done) state_nxt = S_EXP_MUL;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op = OP_NONE;
    unique case (state_r)
      S_IDLE:     if (in_valid) cmd.op = OP_LOAD;
      S_KEY_INIT: cmd.op = OP_KEY_INIT;
      S_KEY_CHK:  cmd.op = OP_NONE;
      S_CAND: begin
        if (!sts.i_ge_t) cmd.op = sts.i_is_pq ? OP_NEXT_I : OP_DIV_T;
      end
      S_DIV_T: begin
        if (sts.div_done) cmd.op = sts.div_rem_zero ? OP_NEXT_I : OP_PRIME_INIT;
      end
      S_PRIME:    cmd.op = sts.fsq_gt_i ? OP_SET_E : OP_DIV_PRIME;
      S_DIV_F: begin
        if (sts.div_done) cmd.op = sts.div_rem_zero ? OP_NEXT_I : OP_NEXT_F;
      end
      S_ACC:      cmd.op = OP_ACC_ADD;
      S_DIV_D_ST: cmd.op = OP_DIV_D;
      S_DIV_D: begin
        if (sts.div_done && sts.div_rem_zero) cmd.op = OP_SET_D;
      end
      S_EXP_INIT: cmd.op = OP_EXP_INIT;
      S_EXP_MUL:  if (!sts.cnt_zero) cmd.op = OP_MUL;
      S_EXP_DIV_ST: cmd.op = OP_DIV_EXP;
      S_EXP_DIV:  if (sts.div_done) cmd.op = OP_SET_R;
      S_OUT:      if (out_free) cmd.op = OP_OUT;
      default:    cmd.op = OP_NONE;
    endcase
  end

  // key flag and output valid
  always_comb begin
    keys_valid_nxt = keys_valid_r;
    if (cfg_hit) begin
      keys_valid_nxt = 1'b0;
    end else if ((state_r == S_KEY_CHK && sts.prime_small) ||
                 (state_r == S_CAND && sts.i_ge_t) ||
                 (state_r == S_DIV_D && sts.div_done && sts.div_rem_zero)) begin
      keys_valid_nxt = 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (state_r == S_OUT && out_free) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      keys_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      keys_valid_r <= keys_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/rsaenc_chk.sv
// Port-level checker for the RSA character encryptor, bound to the top level.
// Uses rsaenc_pkg payload types.
module rsaenc_chk
  import rsaenc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item in flight
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_byte_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cipher_byte ==
                  8'(out_data.cipher_residue[7:0] + 8'(PT_OFFSET)))
    else $error("cipher byte disagrees with residue");

  a_no_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.public_exponent == 16'd0) |->
      (out_data.cipher_residue == 17'sd0) && (out_data.private_exponent == 16'd0))
    else $error("nonzero result without keys");

endmodule

bind toy_rsa_char_encryptor rsaenc_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
